// File: hdl/dnle_pkg.sv
// Shared types and constants of the DNS name label encoder.
package dnle_pkg;

    localparam logic [7:0] DOT_CODE  = 8'd46;
    localparam logic [6:0] MAX_LABEL = 7'd63;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY_LBL = 2'd1;
    localparam logic [1:0] ST_LONG_LBL  = 2'd2;
    localparam logic [1:0] ST_NO_SPACE  = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       is_dot;
        logic       end_of_name;
    } t_item;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_byte;
        logic        name_done;
        logic [1:0]  status;
        logic [15:0] encoded_length;
        logic        last_of_run;
    } t_result;

endpackage

// File: hdl/dnle_front.sv
// Front part: accepts and classifies characters and queues them for the back part.
module dnle_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      i_char_code,
    input  logic            i_has_char,
    input  logic            i_end_of_name,
    output logic            o_item_valid,
    output dnle_pkg::t_item o_item,
    input  logic            i_item_take
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dnle_pkg::t_item r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    dnle_pkg::t_item w_item;
    logic            w_accept;
    logic            w_store;
    logic            w_take;

    always_comb begin
        w_item.char_code   = i_char_code;
        w_item.has_char    = i_has_char;
        w_item.is_dot      = i_has_char && (i_char_code == dnle_pkg::DOT_CODE);
        w_item.end_of_name = i_end_of_name;
    end

    assign full         = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_accept     = push && !full;
    // drop items that cause no result
    assign w_store      = w_accept && (i_has_char || i_end_of_name);
    assign o_item_valid = (r_count != '0);
    assign w_take       = i_item_take && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_store) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_take) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_store && !w_take) begin
            n_count = r_count + 1'b1;
        end else if (!w_store && w_take) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

// File: hdl/dnle_back.sv
// Back part: label state, write sequencing and the result register.
module dnle_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic              i_item_valid,
    input  dnle_pkg::t_item   i_item,
    output logic              o_item_take,
    output logic              o_res_valid,
    output dnle_pkg::t_result o_res,
    input  logic              i_res_take
);

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_CLOSE = 2'd1;
    localparam logic [1:0] PH_TERM  = 2'd2;

    logic [15:0] r_capacity;
    logic [15:0] r_start, n_start;
    logic [6:0]  r_len, n_len;
    logic [1:0]  r_err, n_err;
    logic [1:0]  r_phase, n_phase;
    logic        r_out_valid;
    dnle_pkg::t_result r_out, n_out;

    logic        w_step;
    logic [1:0]  w_ph;
    logic [1:0]  w_close_err;
    logic [17:0] w_close_end;
    logic [17:0] w_char_addr;
    logic [16:0] w_term_need;
    logic        w_char_ok;
    logic [1:0]  w_term_err;
    logic        w_pop_item;

    assign w_step      = i_item_valid && (!r_out_valid || i_res_take);
    assign o_item_take = w_step && w_pop_item;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign w_close_end = {2'b00, r_start} + {11'd0, r_len} + 18'd2;
    assign w_char_addr = {2'b00, r_start} + {11'd0, r_len} + 18'd1;
    assign w_term_need = {1'b0, r_start} + 17'd1;

    always_comb begin
        w_close_err = r_err;
        if (r_err == dnle_pkg::ST_OK) begin
            if (r_len == '0) begin
                w_close_err = dnle_pkg::ST_EMPTY_LBL;
            end else if (r_len > dnle_pkg::MAX_LABEL) begin
                w_close_err = dnle_pkg::ST_LONG_LBL;
            end else if (w_close_end > {2'b00, r_capacity}) begin
                w_close_err = dnle_pkg::ST_NO_SPACE;
            end
        end
    end

    assign w_char_ok = (r_err == dnle_pkg::ST_OK) && (r_len < dnle_pkg::MAX_LABEL)
                       && (w_char_addr < {2'b00, r_capacity});

    assign w_term_err = ((r_err == dnle_pkg::ST_OK) && (w_term_need > {1'b0, r_capacity}))
                        ? dnle_pkg::ST_NO_SPACE : r_err;

    always_comb begin
        w_ph = r_phase;
        if (r_phase == PH_FIRST && !i_item.has_char) begin
            w_ph = PH_CLOSE;
        end
        if (w_ph == PH_CLOSE && !(r_err == dnle_pkg::ST_OK && r_len != '0)) begin
            w_ph = PH_TERM;
        end
    end

    always_comb begin
        n_start    = r_start;
        n_len      = r_len;
        n_err      = r_err;
        n_phase    = r_phase;
        w_pop_item = 1'b0;
        n_out      = '0;
        case (w_ph)
            PH_FIRST: begin
                if (i_item.is_dot) begin
                    n_err = w_close_err;
                    n_len = '0;
                    if (w_close_err == dnle_pkg::ST_OK) begin
                        n_out.write_enable  = 1'b1;
                        n_out.write_address = r_start;
                        n_out.write_byte    = {1'b0, r_len};
                        n_start = r_start + {9'd0, r_len} + 16'd1;
                    end else begin
                        n_out.status = w_close_err;
                    end
                end else begin
                    if (w_char_ok) begin
                        n_out.write_enable  = 1'b1;
                        n_out.write_address = w_char_addr[15:0];
                        n_out.write_byte    = i_item.char_code;
                    end else begin
                        n_out.status = r_err;
                    end
                    if (r_len < dnle_pkg::MAX_LABEL + 7'd1) begin
                        n_len = r_len + 7'd1;
                    end
                end
                n_out.last_of_run = !i_item.end_of_name;
                n_phase           = i_item.end_of_name ? PH_CLOSE : PH_FIRST;
                w_pop_item        = !i_item.end_of_name;
            end
            PH_CLOSE: begin
                n_err = w_close_err;
                n_len = '0;
                if (w_close_err == dnle_pkg::ST_OK) begin
                    n_out.write_enable  = 1'b1;
                    n_out.write_address = r_start;
                    n_out.write_byte    = {1'b0, r_len};
                    n_start = r_start + {9'd0, r_len} + 16'd1;
                end else begin
                    n_out.status = w_close_err;
                end
                n_phase = PH_TERM;
            end
            PH_TERM: begin
                n_out.name_done   = 1'b1;
                n_out.last_of_run = 1'b1;
                if (w_term_err == dnle_pkg::ST_OK) begin
                    n_out.write_enable   = 1'b1;
                    n_out.write_address  = r_start;
                    n_out.encoded_length = w_term_need[15:0];
                end else begin
                    n_out.status = w_term_err;
                end
                n_start    = '0;
                n_len      = '0;
                n_err      = dnle_pkg::ST_OK;
                n_phase    = PH_FIRST;
                w_pop_item = 1'b1;
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= 16'd256;
            r_start     <= '0;
            r_len       <= '0;
            r_err       <= dnle_pkg::ST_OK;
            r_phase     <= PH_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (w_step) begin
                r_start     <= n_start;
                r_len       <= n_len;
                r_err       <= n_err;
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (i_res_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hdl/dns_name_label_encoder.sv
// Top level of the DNS name label encoder.
//
//  channel   handshake           payload
//  input     push / full         i_char_code, i_has_char, i_end_of_name
//  result    empty / pop         o_write_enable .. o_last_of_run
//  config    i_cfg_wr_en         i_cfg_wr_data (out_capacity)
//
// One input item per cycle is accepted while the front queue has room.
// Characters and dots give one result each, one per cycle through the back sequencer
// while the result register is free; the closing item of a name gives up to three
// results. An accepted item reaches the ports through the front queue and then the
// result register. A stalled result register holds the back part; the front queue
// keeps accepting until QUEUE_DEPTH items wait. Reset is synchronous, active low.
module dns_name_label_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_has_char,
    input  logic        i_end_of_name,
    output logic        empty,
    input  logic        pop,
    output logic        o_write_enable,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_byte,
    output logic        o_name_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_encoded_length,
    output logic        o_last_of_run
);

    logic              w_item_valid;
    dnle_pkg::t_item   w_item;
    logic              w_item_take;
    logic              w_res_valid;
    dnle_pkg::t_result w_res;

    dnle_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_char_code   (i_char_code),
        .i_has_char    (i_has_char),
        .i_end_of_name (i_end_of_name),
        .o_item_valid  (w_item_valid),
        .o_item        (w_item),
        .i_item_take   (w_item_take)
    );

    dnle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item_valid  (w_item_valid),
        .i_item        (w_item),
        .o_item_take   (w_item_take),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res),
        .i_res_take    (pop)
    );

    assign empty            = !w_res_valid;
    assign o_write_enable   = w_res.write_enable;
    assign o_write_address  = w_res.write_address;
    assign o_write_byte     = w_res.write_byte;
    assign o_name_done      = w_res.name_done;
    assign o_status         = w_res.status;
    assign o_encoded_length = w_res.encoded_length;
    assign o_last_of_run    = w_res.last_of_run;

endmodule

// File: tb/sv/dnle_write_checker.sv
// Checker that predicts the DNS wire-form buffer writes and compares them with the results.
module dnle_write_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_char_code,
    input  logic        i_has_char,
    input  logic        i_end_of_name,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_write_enable,
    input  logic [15:0] i_write_address,
    input  logic [7:0]  i_write_byte,
    input  logic        i_name_done,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_encoded_length,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    dnle_pkg::t_result writes_due[$];
    logic [15:0] capacity;
    logic [15:0] lbl_start;
    logic [6:0]  lbl_len;
    logic [1:0]  err;
    int          fails;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fails++;
        $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    function automatic void add_write(input logic we, input logic [15:0] addr,
                                      input logic [7:0] data, input logic done,
                                      input logic [1:0] st, input logic [15:0] enc);
        dnle_pkg::t_result r;
        r.write_enable   = we;
        r.write_address  = we ? addr : 16'd0;
        r.write_byte     = we ? data : 8'd0;
        r.name_done      = done;
        r.status         = st;
        r.encoded_length = enc;
        r.last_of_run    = 1'b0;
        writes_due.push_back(r);
    endfunction

    function automatic void close_label();
        int unsigned span;
        span = lbl_start + lbl_len + 2;
        if (err == dnle_pkg::ST_OK) begin
            if (lbl_len == 7'd0) begin
                err = dnle_pkg::ST_EMPTY_LBL;
            end else if (lbl_len > dnle_pkg::MAX_LABEL) begin
                err = dnle_pkg::ST_LONG_LBL;
            end else if (span > capacity) begin
                err = dnle_pkg::ST_NO_SPACE;
            end
        end
        if (err == dnle_pkg::ST_OK) begin
            add_write(1'b1, lbl_start, {1'b0, lbl_len}, 1'b0, dnle_pkg::ST_OK, 16'd0);
            lbl_start = lbl_start + lbl_len + 16'd1;
        end else begin
            add_write(1'b0, 16'd0, 8'd0, 1'b0, err, 16'd0);
        end
        lbl_len = 7'd0;
    endfunction

    function automatic void encode_item(input logic [7:0] ch, input logic has,
                                        input logic eon);
        int          prior_size;
        int unsigned slot;
        prior_size = writes_due.size();
        if (has && ch == dnle_pkg::DOT_CODE) begin
            close_label();
        end else if (has) begin
            slot = lbl_start + 1 + lbl_len;
            if (err == dnle_pkg::ST_OK && lbl_len < dnle_pkg::MAX_LABEL && slot < capacity) begin
                add_write(1'b1, slot[15:0], ch, 1'b0, dnle_pkg::ST_OK, 16'd0);
            end else begin
                add_write(1'b0, 16'd0, 8'd0, 1'b0, err, 16'd0);
            end
            if (lbl_len <= dnle_pkg::MAX_LABEL) begin
                lbl_len = lbl_len + 7'd1;
            end
        end
        if (eon) begin
            if (err == dnle_pkg::ST_OK && lbl_len != 7'd0) begin
                close_label();
            end
            slot = lbl_start + 1;
            if (err == dnle_pkg::ST_OK && slot > capacity) begin
                err = dnle_pkg::ST_NO_SPACE;
            end
            if (err == dnle_pkg::ST_OK) begin
                add_write(1'b1, lbl_start, 8'd0, 1'b1, dnle_pkg::ST_OK, slot[15:0]);
            end else begin
                add_write(1'b0, 16'd0, 8'd0, 1'b1, err, 16'd0);
            end
            lbl_start = 16'd0;
            lbl_len   = 7'd0;
            err       = dnle_pkg::ST_OK;
        end
        if (writes_due.size() > prior_size) begin
            writes_due[writes_due.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        dnle_pkg::t_result want;
        if (!i_rst_n) begin
            capacity  = 16'd256;
            lbl_start = 16'd0;
            lbl_len   = 7'd0;
            err       = dnle_pkg::ST_OK;
            writes_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                capacity = i_cfg_wr_data;
            end
            if (i_pop && !i_empty) begin
                if (writes_due.size() == 0) begin
                    report_mismatch("result transfer with nothing due", 16'd0, 16'd0);
                end else begin
                    want = writes_due.pop_front();
                    if (i_write_enable !== want.write_enable)
                        report_mismatch("write_enable", 16'(i_write_enable),
                                        16'(want.write_enable));
                    if (i_write_address !== want.write_address)
                        report_mismatch("write_address", i_write_address,
                                        want.write_address);
                    if (i_write_byte !== want.write_byte)
                        report_mismatch("write_byte", 16'(i_write_byte),
                                        16'(want.write_byte));
                    if (i_name_done !== want.name_done)
                        report_mismatch("name_done", 16'(i_name_done),
                                        16'(want.name_done));
                    if (i_status !== want.status)
                        report_mismatch("status", 16'(i_status), 16'(want.status));
                    if (i_encoded_length !== want.encoded_length)
                        report_mismatch("encoded_length", i_encoded_length,
                                        want.encoded_length);
                    if (i_last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 16'(i_last_of_run),
                                        16'(want.last_of_run));
                end
            end
            if (i_push && !i_full) begin
                encode_item(i_char_code, i_has_char, i_end_of_name);
            end
        end
        o_pending    <= writes_due.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/sv/tb_dns_name_label_encoder.sv
// Testbench top for the DNS name label encoder: stimulus, idling and verdict.
module tb_dns_name_label_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 4;
    localparam int NUM_PHASES  = 9;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef enum int {END_ON_CHAR, END_ALONE, END_ON_DOT, DOT_THEN_END} t_name_end;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        push;
    logic        full;
    logic [7:0]  char_code;
    logic        has_char;
    logic        end_of_name;
    logic        empty;
    logic        pop = 1'b0;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_byte;
    logic        name_done;
    logic [1:0]  status;
    logic [15:0] encoded_length;
    logic        last_of_run;
    logic        no_idle = 1'b0;
    int          mismatches;
    int          pending;
    int          items_sent = 0;

    dns_name_label_encoder i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .push             (push),
        .full             (full),
        .i_char_code      (char_code),
        .i_has_char       (has_char),
        .i_end_of_name    (end_of_name),
        .empty            (empty),
        .pop              (pop),
        .o_write_enable   (write_enable),
        .o_write_address  (write_address),
        .o_write_byte     (write_byte),
        .o_name_done      (name_done),
        .o_status         (status),
        .o_encoded_length (encoded_length),
        .o_last_of_run    (last_of_run)
    );

    dnle_write_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_push           (push),
        .i_full           (full),
        .i_char_code      (char_code),
        .i_has_char       (has_char),
        .i_end_of_name    (end_of_name),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_write_enable   (write_enable),
        .i_write_address  (write_address),
        .i_write_byte     (write_byte),
        .i_name_done      (name_done),
        .i_status         (status),
        .i_encoded_length (encoded_length),
        .i_last_of_run    (last_of_run),
        .o_fail_count     (mismatches),
        .o_pending        (pending)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(negedge clk) begin
        pop <= no_idle || ($urandom_range(0, 99) >= 24);
    end

    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == dnle_pkg::DOT_CODE);
        return c;
    endfunction

    function automatic logic [15:0] phase_capacity(input int p);
        case (p)
            0:       return 16'hFFFF;
            1:       return 16'd1;
            2:       return 16'd0;
            3:       return 16'd3;
            4:       return 16'd9;
            5:       return 16'd17;
            6:       return 16'd40;
            7:       return 16'($urandom_range(41, 65535));
            default: return 16'd256;
        endcase
    endfunction

    task automatic send_item(input logic [7:0] ch, input logic has, input logic eon);
        while (!no_idle && $urandom_range(0, 99) < 24) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push        <= 1'b1;
        char_code   <= ch;
        has_char    <= has;
        end_of_name <= eon;
        do @(posedge clk); while (full);
        @(negedge clk);
        if (has || eon) items_sent++;
    endtask

    task automatic send_chars(input int n, input logic end_on_last);
        for (int c = 0; c < n; c++) begin
            send_item(rand_char(), 1'b1, end_on_last && c == n - 1);
        end
    endtask

    task automatic send_name();
        int        labels;
        t_name_end tail;
        labels = $urandom_range(1, 4);
        tail   = t_name_end'($urandom_range(0, 3));
        for (int l = 0; l < labels; l++) begin
            send_chars($urandom_range(1, 8), tail == END_ON_CHAR && l == labels - 1);
            if (l < labels - 1) send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b0);
        end
        case (tail)
            END_ALONE: begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            END_ON_DOT: begin
                send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b1);
            end
            DOT_THEN_END: begin
                send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic send_noise();
        int         n;
        logic [7:0] ch;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            ch = ($urandom_range(0, 99) < 30) ? dnle_pkg::DOT_CODE
                                              : 8'($urandom_range(0, 255));
            send_item(ch, 1'($urandom_range(0, 3) != 0), k == n - 1);
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty)) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int start;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 16'd0;
        push        = 1'b0;
        char_code   = 8'd0;
        has_char    = 1'b0;
        end_of_name = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty name, single character name
        send_item(8'd0, 1'b0, 1'b1);
        send_item("a", 1'b1, 1'b1);
        // two labels, end on its own item carrying a dot code that must be ignored
        send_item("a", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b0);
        send_item(dnle_pkg::DOT_CODE, 1'b0, 1'b1);
        // trailing dot, lone dot
        send_item("x", 1'b1, 1'b0);
        send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b1);
        send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b1);
        // two dots in a row, then a character under a sticky error
        send_item("a", 1'b1, 1'b0);
        send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b0);
        send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b1);
        // leading dot
        send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b0);
        send_item("q", 1'b1, 1'b1);
        // idle item, character codes zero and all ones
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_capacity(phase_capacity(p));
            if (p == 0) begin
                // label limits with back-to-back transfers on both sides
                no_idle <= 1'b1;
                send_chars(63, 1'b0);
                send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b0);
                send_chars(1, 1'b1);
                send_chars(64, 1'b1);
                send_chars(66, 1'b0);
                send_item(dnle_pkg::DOT_CODE, 1'b1, 1'b0);
                send_chars(1, 1'b0);
                send_item(8'd0, 1'b0, 1'b1);
                no_idle <= 1'b0;
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 75) send_name();
                else send_noise();
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
